[hdl/gbcd_pkg.sv]
package gbcd_pkg;

	// Field and state widths.
	localparam int RAW_W    = 16;
	localparam int CNT_W    = 8;
	localparam int SUM_W    = 24;
	localparam int SQ_W     = 39;
	localparam int DEV_W    = 16;
	localparam int RATE_W   = 21;
	localparam int FS_W     = 11;
	localparam int NUM_AXES = 3;

	// Serial divider and square root sizes.
	localparam int DIV_W  = 47;
	localparam int DVS_W  = 16;
	localparam int ROOT_W = 24;
	localparam int RAD_W  = 2 * ROOT_W;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd2;

	// Configuration reset values.
	localparam logic [CNT_W-1:0] RST_CALIB_COUNT = 8'd50;
	localparam logic [CNT_W-1:0] RST_THRESHOLD   = 8'd0;
	localparam logic [1:0]       RST_SCALE       = 2'd3;

	// Full scale in degrees per second for each scale code.
	function automatic logic [FS_W-1:0] full_scale_dps(input logic [1:0] sel);
		logic [FS_W-1:0] fs;
		case (sel)
			2'd0:    fs = 11'd250;
			2'd1:    fs = 11'd500;
			2'd2:    fs = 11'd1000;
			default: fs = 11'd2000;
		endcase
		return fs;
	endfunction

endpackage

[hdl/gbcd_if.sv]
interface gbcd_sample_if;
	import gbcd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    command;
	logic signed [RAW_W-1:0] raw_x;
	logic signed [RAW_W-1:0] raw_y;
	logic signed [RAW_W-1:0] raw_z;
	modport source(output valid, command, raw_x, raw_y, raw_z, input ready);
	modport sink(input valid, command, raw_x, raw_y, raw_z, output ready);
endinterface

interface gbcd_result_if;
	import gbcd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] rate_x;
	logic signed [RATE_W-1:0] rate_y;
	logic signed [RATE_W-1:0] rate_z;
	logic                     is_calibrated;
	logic                     calib_done;
	modport source(output valid, rate_x, rate_y, rate_z, is_calibrated, calib_done,
		input ready);
	modport sink(input valid, rate_x, rate_y, rate_z, is_calibrated, calib_done,
		output ready);
endinterface

interface gbcd_cfg_if;
	import gbcd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CNT_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/gbcd_div.sv]
module gbcd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gbcd_pkg::DIV_W-1:0]  dividend,
	input  logic [gbcd_pkg::DVS_W-1:0]  divisor,
	output logic                        done,
	output logic [gbcd_pkg::DIV_W-1:0]  quotient
);
	import gbcd_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] shreg_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_nx;
	logic             ge;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		rem_sh = {rem_q, shreg_q[DIV_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	// Control: iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath: dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= dividend;
			dvs_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[DIV_W-2:0], ge};
			rem_q   <= rem_nx[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = shreg_q;
endmodule

[hdl/gbcd_sqrt.sv]
module gbcd_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gbcd_pkg::RAD_W-1:0]   radicand,
	output logic                         done,
	output logic [gbcd_pkg::ROOT_W-1:0]  root
);
	import gbcd_pkg::*;

	localparam int CW = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W:0]   rem_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] rem_nx;
	logic              ge;

	// One root digit per cycle from the next two radicand bits.
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	// Control: iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], ge};
			rem_q  <= rem_nx[ROOT_W:0];
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

[hdl/gyro_bias_calibrate_deadband_core.sv]
// Channel   Direction  Carries
// sample    in         command, raw_x, raw_y, raw_z
// result    out        rate_x, rate_y, rate_z, is_calibrated, calib_done
// cfg       in         index, data (0 count, 1 threshold, 2 scale)
//
// One item is processed at a time; the axes go through one after another.
// The sample that completes a run waits on the bit-serial divider, twice per
// axis, and on the square root unit, once per axis.
// Reset clears all sums, bias, deviation and the calibrated flag.
// A held result does not block the next sample; it only stalls its finish.
module gyro_bias_calibrate_deadband_core (
	input  logic          clk,
	input  logic          arst_n,
	gbcd_sample_if.sink   sample,
	gbcd_result_if.source result,
	gbcd_cfg_if.sink      cfg
);
	import gbcd_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_C_MUL    = 4'd1;
	localparam logic [3:0] S_C_ADD    = 4'd2;
	localparam logic [3:0] S_F_MUL    = 4'd3;
	localparam logic [3:0] S_F_SQR    = 4'd4;
	localparam logic [3:0] S_F_DIVB   = 4'd5;
	localparam logic [3:0] S_F_DIVB_W = 4'd6;
	localparam logic [3:0] S_F_DIVV   = 4'd7;
	localparam logic [3:0] S_F_DIVV_W = 4'd8;
	localparam logic [3:0] S_F_SQRT_W = 4'd9;
	localparam logic [3:0] S_M_SUB    = 4'd10;
	localparam logic [3:0] S_M_GATE   = 4'd11;
	localparam logic [3:0] S_M_SCALE  = 4'd12;
	localparam logic [3:0] S_OUT      = 4'd13;

	localparam logic [1:0] LAST_AXIS = 2'(NUM_AXES - 1);

	logic [3:0] state_q;
	logic [1:0] axis_q;

	logic [CNT_W-1:0] cfg_count_q;
	logic [CNT_W-1:0] cfg_thr_q;
	logic [1:0]       cfg_scale_q;

	logic signed [RAW_W-1:0]  raw_q   [NUM_AXES];
	logic signed [SUM_W-1:0]  sum_q   [NUM_AXES];
	logic [SQ_W-1:0]          sqsum_q [NUM_AXES];
	logic signed [RAW_W-1:0]  bias_q  [NUM_AXES];
	logic [DEV_W-1:0]         dev_q   [NUM_AXES];
	logic signed [RATE_W-1:0] rate_q  [NUM_AXES];
	logic                     flag_q;
	logic                     done_q;
	logic [CNT_W-1:0]         counter_q;
	logic [CNT_W-1:0]         nsamp_q;

	logic [31:0]              sq_q;
	logic [DIV_W-1:0]         a_q;
	logic [RAD_W-1:0]         b_q;
	logic [SUM_W-1:0]         smag_q;
	logic                     sum_neg_q;
	logic [DVS_W-1:0]         nn_q;
	logic signed [17:0]       c_q;
	logic [23:0]              lim_q;
	logic signed [29:0]       prod_q;

	logic                     res_valid_q;
	logic signed [RATE_W-1:0] res_x_q;
	logic signed [RATE_W-1:0] res_y_q;
	logic signed [RATE_W-1:0] res_z_q;
	logic                     res_cal_q;
	logic                     res_done_q;

	logic signed [RAW_W-1:0] raw_sel;
	logic signed [RAW_W:0]   raw_ext;
	logic [RAW_W:0]          raw_mag;
	logic [33:0]             sq_full;
	logic signed [SUM_W-1:0] sum_sel;
	logic [CNT_W-1:0]        cnt_inc;
	logic [CNT_W-1:0]        n_eff;
	logic [DIV_W-1:0]        a_full;
	logic [RAD_W-1:0]        diff_full;
	logic [DIV_W-1:0]        diff;
	logic signed [17:0]      c_full;
	logic [17:0]             c_mag;
	logic signed [17:0]      c_gated;
	logic signed [29:0]      prod_full;
	logic signed [29:0]      prod_adj;
	logic signed [22:0]      r_sh;
	logic signed [RATE_W-1:0] r_sat;
	logic                    out_free;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_q;
	logic             sqrt_start;
	logic             sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;

	// Per-axis operand selection and arithmetic.
	always_comb begin
		raw_sel   = raw_q[axis_q];
		raw_ext   = {raw_sel[RAW_W-1], raw_sel};
		raw_mag   = raw_ext[RAW_W] ? -raw_ext : raw_ext;
		sq_full   = {17'b0, raw_mag} * {17'b0, raw_mag};
		sum_sel   = sum_q[axis_q];
		cnt_inc   = counter_q + CNT_W'(1);
		n_eff     = (cfg_count_q == '0) ? CNT_W'(1) : cfg_count_q;
		a_full    = DIV_W'(nsamp_q) * DIV_W'(sqsum_q[axis_q]);
		diff_full = ({1'b0, a_q} > b_q) ? ({1'b0, a_q} - b_q) : '0;
		diff      = diff_full[DIV_W-1:0];
		c_full    = 18'(raw_sel) - (flag_q ? 18'(bias_q[axis_q]) : 18'sd0);
		c_mag     = c_q[17] ? 18'(-c_q) : 18'(c_q);
		c_gated   = ((cfg_thr_q != '0) && ({6'b0, c_mag} < lim_q)) ? 18'sd0 : c_q;
		prod_full = 30'(c_gated) * 30'($signed({1'b0, full_scale_dps(cfg_scale_q)}));
		prod_adj  = prod_q + (prod_q[29] ? 30'sd127 : 30'sd0);
		r_sh      = prod_adj[29:7];
		if (r_sh[22:20] == 3'b000 || r_sh[22:20] == 3'b111)
			r_sat = r_sh[RATE_W-1:0];
		else if (r_sh[22])
			r_sat = {1'b1, {(RATE_W-1){1'b0}}};
		else
			r_sat = {1'b0, {(RATE_W-1){1'b1}}};
		out_free = !res_valid_q || result.ready;
	end

	// Shared divider serves both the bias and the variance.
	always_comb begin
		div_start    = (state_q == S_F_DIVB) || (state_q == S_F_DIVV);
		div_dividend = (state_q == S_F_DIVB) ? DIV_W'(smag_q) : diff;
		div_divisor  = (state_q == S_F_DIVB) ? DVS_W'(nsamp_q) : nn_q;
		sqrt_start   = (state_q == S_F_DIVV_W) && div_done;
	end

	gbcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	gbcd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (RAD_W'(div_q)),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= RST_CALIB_COUNT;
			cfg_thr_q   <= RST_THRESHOLD;
			cfg_scale_q <= RST_SCALE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_CALIB_COUNT: cfg_count_q <= cfg.data;
				CFG_THRESHOLD:   cfg_thr_q   <= cfg.data;
				CFG_SCALE:       cfg_scale_q <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and calibration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			flag_q      <= 1'b0;
			done_q      <= 1'b0;
			counter_q   <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				sum_q[i]   <= '0;
				sqsum_q[i] <= '0;
				bias_q[i]  <= '0;
				dev_q[i]   <= '0;
			end
		end else begin
			// The result register fills from S_OUT and empties on a transaction.
			if ((state_q == S_OUT) && out_free)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						axis_q  <= '0;
						done_q  <= 1'b0;
						state_q <= sample.command ? S_C_MUL : S_M_SUB;
					end
				end
				S_C_MUL: state_q <= S_C_ADD;
				S_C_ADD: begin
					sum_q[axis_q]   <= sum_sel + SUM_W'(raw_sel);
					sqsum_q[axis_q] <= sqsum_q[axis_q] + SQ_W'(sq_q);
					if (axis_q != LAST_AXIS) begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_C_MUL;
					end else if (cnt_inc >= n_eff) begin
						counter_q <= '0;
						axis_q    <= '0;
						state_q   <= S_F_MUL;
					end else begin
						counter_q <= cnt_inc;
						state_q   <= S_OUT;
					end
				end
				S_F_MUL:  state_q <= S_F_SQR;
				S_F_SQR:  state_q <= S_F_DIVB;
				S_F_DIVB: state_q <= S_F_DIVB_W;
				S_F_DIVB_W: begin
					if (div_done) begin
						bias_q[axis_q] <= sum_neg_q ? -RAW_W'(div_q) : RAW_W'(div_q);
						state_q        <= S_F_DIVV;
					end
				end
				S_F_DIVV: state_q <= S_F_DIVV_W;
				S_F_DIVV_W: begin
					if (div_done)
						state_q <= S_F_SQRT_W;
				end
				S_F_SQRT_W: begin
					if (sqrt_done) begin
						dev_q[axis_q]   <= (sqrt_root[ROOT_W-1:DEV_W] != '0) ?
							{DEV_W{1'b1}} : sqrt_root[DEV_W-1:0];
						sum_q[axis_q]   <= '0;
						sqsum_q[axis_q] <= '0;
						if (axis_q != LAST_AXIS) begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_F_MUL;
						end else begin
							flag_q  <= 1'b1;
							done_q  <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_M_SUB:  state_q <= S_M_GATE;
				S_M_GATE: state_q <= S_M_SCALE;
				S_M_SCALE: begin
					if (axis_q != LAST_AXIS) begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_M_SUB;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (sample.valid) begin
					raw_q[0] <= sample.raw_x;
					raw_q[1] <= sample.raw_y;
					raw_q[2] <= sample.raw_z;
					for (int i = 0; i < NUM_AXES; i++)
						rate_q[i] <= '0;
				end
			end
			S_C_MUL: sq_q <= sq_full[31:0];
			S_C_ADD: nsamp_q <= cnt_inc;
			S_F_MUL: begin
				a_q       <= a_full;
				smag_q    <= sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
				sum_neg_q <= sum_sel[SUM_W-1];
				nn_q      <= DVS_W'(nsamp_q) * DVS_W'(nsamp_q);
			end
			S_F_SQR: b_q <= RAD_W'(smag_q) * RAD_W'(smag_q);
			S_M_SUB: begin
				c_q   <= c_full;
				lim_q <= 24'(cfg_thr_q) * 24'(dev_q[axis_q]);
			end
			S_M_GATE:  prod_q <= prod_full;
			S_M_SCALE: rate_q[axis_q] <= r_sat;
			S_OUT: begin
				if (out_free) begin
					res_x_q    <= rate_q[0];
					res_y_q    <= rate_q[1];
					res_z_q    <= rate_q[2];
					res_cal_q  <= flag_q;
					res_done_q <= done_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid         = res_valid_q;
	assign result.rate_x        = res_x_q;
	assign result.rate_y        = res_y_q;
	assign result.rate_z        = res_z_q;
	assign result.is_calibrated = res_cal_q;
	assign result.calib_done    = res_done_q;

	// A completed run always leaves the block calibrated.
	a_done_cal: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.calib_done |-> result.is_calibrated)
		else $error("calib_done without is_calibrated");

	// A result that completes a calibration run carries zero rates.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.calib_done |->
		(result.rate_x == '0) && (result.rate_y == '0) && (result.rate_z == '0))
		else $error("calibration result with nonzero rate");

	// The divider only finishes while the sequencer waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_F_DIVB_W) || (state_q == S_F_DIVV_W))
		else $error("divider finished outside a wait state");

	// The stored sample count never reaches the largest count.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q != {CNT_W{1'b1}})
		else $error("sample counter overflow");
endmodule
